FILE: rtl/core/battery_level_averager_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery level averager
// Concurrent check macros that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_AVERAGER_TOP_ASSERT_SVH
`define BATTERY_LEVEL_AVERAGER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define BLA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define BLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define BLA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/batt_avg_pkg.sv
// ----------------------------------------------------------------------------
// Battery level averager package
// Field widths, level codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package batt_avg_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int TIME_W      = 32;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [1:0] {
		LEVEL_FULL    = 2'd0,
		LEVEL_TWO_BAR = 2'd1,
		LEVEL_ONE_BAR = 2'd2,
		LEVEL_EMPTY   = 2'd3
	} level_t;

	localparam logic [CFG_INDEX_W-1:0] CFG_FULL_THR    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TWO_BAR_THR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THR     = 2'd2;

	localparam logic [SAMPLE_W-1:0] FULL_THR_RESET    = 12'd3050;
	localparam logic [SAMPLE_W-1:0] TWO_BAR_THR_RESET = 12'd2800;
	localparam logic [SAMPLE_W-1:0] LOW_THR_RESET     = 12'd2550;

	// The blink phase is the parity of floor(time / 1000), computed as
	// floor((time >> 3) / 125) by a reciprocal multiplication.
	localparam int BLINK_PRESHIFT = 3;
	localparam int BLINK_X_W      = TIME_W - BLINK_PRESHIFT;
	localparam int BLINK_MUL_W    = 30;
	localparam int BLINK_PROD_W   = BLINK_X_W + BLINK_MUL_W;
	localparam int BLINK_SHIFT    = 36;
	localparam logic [BLINK_MUL_W-1:0] BLINK_MUL = 30'd549755814;

endpackage

FILE: rtl/core/batt_avg_if.sv
// ----------------------------------------------------------------------------
// Battery level averager channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface batt_avg_item_if
	import batt_avg_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0]   time_ms;

	modport source (output valid, output sample, output time_ms, input ready);
	modport sink (input valid, input sample, input time_ms, output ready);
endinterface

interface batt_avg_result_if
	import batt_avg_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] average;
	level_t              level;
	logic                show_graphic;
	logic                battery_low;

	modport source (output valid, output average, output level, output show_graphic,
		output battery_low, input ready);
	modport sink (input valid, input average, input level, input show_graphic,
		input battery_low, output ready);
endinterface

interface batt_avg_cfg_if
	import batt_avg_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [SAMPLE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/battery_level_averager_top.sv
// ----------------------------------------------------------------------------
// Battery level averager
// Each sample passes the s1, s2 and output registers; a held result stalls the pipeline.
// One sample per cycle unless stalled; ring memory is read and written in the same cycle.
// The running sum updates as each beat leaves s1, so consecutive beats need no interlock.
// Reset clears the sum, the ring pointer and the fill flag; ring entries count as zero
// until the first pass writes them. Thresholds reset to 3050, 2800 and 2550.
// ----------------------------------------------------------------------------
`include "battery_level_averager_top_assert.svh"

module battery_level_averager_top
	import batt_avg_pkg::*;
#(
	parameter int WINDOW = 128
) (
	input logic               clk,
	input logic               arst_n,
	batt_avg_item_if.sink     sample_ch,
	batt_avg_cfg_if.sink      cfg,
	batt_avg_result_if.source result_ch
);

	localparam int IDX_W      = $clog2(WINDOW);
	localparam int SUM_W      = SAMPLE_W + IDX_W;
	localparam int AVG_SHIFT  = SUM_W + IDX_W;
	localparam int AVG_MUL_W  = SUM_W + 1;
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL =
		AVG_MUL_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [SUM_W-1:0] FULL_RESET_SCALED    =
		SUM_W'(FULL_THR_RESET) * SUM_W'(WINDOW);
	localparam logic [SUM_W-1:0] TWO_BAR_RESET_SCALED =
		SUM_W'(TWO_BAR_THR_RESET) * SUM_W'(WINDOW);
	localparam logic [SUM_W-1:0] LOW_RESET_SCALED     =
		SUM_W'(LOW_THR_RESET) * SUM_W'(WINDOW);

	logic                    adv;
	logic                    acc;
	logic [IDX_W-1:0]        idx_q;
	logic                    wrapped_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SUM_W-1:0]        sum_next;
	logic [SUM_W-1:0]        full_scaled_q;
	logic [SUM_W-1:0]        two_bar_scaled_q;
	logic [SUM_W-1:0]        low_scaled_q;
	logic [SUM_W-1:0]        cfg_scaled;
	logic [SAMPLE_W-1:0]     ring_mem [WINDOW];

	logic                    v_s1;
	logic [SAMPLE_W-1:0]     rd_s1;
	logic [SAMPLE_W-1:0]     sample_s1;
	logic [SAMPLE_W-1:0]     old_s1;
	logic [BLINK_X_W-1:0]    time_s1;
	logic                    wrapped_s1;
	logic [BLINK_PROD_W-1:0] blink_prod;

	logic                    v_s2;
	logic [SUM_W-1:0]        sum_s2;
	logic                    blink_odd_s2;
	logic [AVG_PROD_W-1:0]   avg_prod;
	level_t                  level_next;

	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     average_q;
	level_t                  level_q;
	logic                    show_q;
	logic                    low_q;

	assign adv             = !out_valid_q || result_ch.ready;
	assign acc             = sample_ch.valid && adv;
	assign sample_ch.ready = adv;
	assign cfg.ready       = 1'b1;
	assign cfg_scaled      = SUM_W'(cfg.data) * SUM_W'(WINDOW);

	assign old_s1     = wrapped_s1 ? rd_s1 : '0;
	assign sum_next   = sum_q - SUM_W'(old_s1) + SUM_W'(sample_s1);
	assign blink_prod = BLINK_PROD_W'(time_s1) * BLINK_PROD_W'(BLINK_MUL);
	assign avg_prod   = AVG_PROD_W'(sum_s2) * AVG_PROD_W'(AVG_MUL);

	always_comb begin
		if (sum_s2 >= full_scaled_q) begin
			level_next = LEVEL_FULL;
		end else if (sum_s2 >= two_bar_scaled_q) begin
			level_next = LEVEL_TWO_BAR;
		end else if (sum_s2 >= low_scaled_q) begin
			level_next = LEVEL_ONE_BAR;
		end else begin
			level_next = LEVEL_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q            <= '0;
			wrapped_q        <= 1'b0;
			sum_q            <= '0;
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			out_valid_q      <= 1'b0;
			full_scaled_q    <= FULL_RESET_SCALED;
			two_bar_scaled_q <= TWO_BAR_RESET_SCALED;
			low_scaled_q     <= LOW_RESET_SCALED;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_FULL_THR: begin
						full_scaled_q <= cfg_scaled;
					end
					CFG_TWO_BAR_THR: begin
						two_bar_scaled_q <= cfg_scaled;
					end
					CFG_LOW_THR: begin
						low_scaled_q <= cfg_scaled;
					end
					default: begin
					end
				endcase
			end
			if (adv) begin
				v_s1        <= acc;
				v_s2        <= v_s1;
				out_valid_q <= v_s2;
				if (acc) begin
					if (idx_q == IDX_W'(WINDOW - 1)) begin
						idx_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				if (v_s1) begin
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ring_mem[idx_q] <= sample_ch.sample;
		end
		if (adv) begin
			rd_s1        <= ring_mem[idx_q];
			sample_s1    <= sample_ch.sample;
			time_s1      <= sample_ch.time_ms[TIME_W-1:BLINK_PRESHIFT];
			wrapped_s1   <= wrapped_q;
			sum_s2       <= sum_next;
			blink_odd_s2 <= blink_prod[BLINK_SHIFT];
			average_q    <= avg_prod[AVG_SHIFT +: SAMPLE_W];
			level_q      <= level_next;
			show_q       <= (level_next == LEVEL_FULL) || (level_next == LEVEL_TWO_BAR) ||
				!blink_odd_s2;
			low_q        <= sum_s2 < low_scaled_q;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.average      = average_q;
	assign result_ch.level        = level_q;
	assign result_ch.show_graphic = show_q;
	assign result_ch.battery_low  = low_q;

	`BLA_ASSERT_NEXT(a_ring_wrap, clk, arst_n, acc && (idx_q == IDX_W'(WINDOW - 1)), (idx_q == '0) && wrapped_q)
	`BLA_ASSERT_NEXT(a_sum_holds_in_stall, clk, arst_n, v_s1 && !adv, v_s1 && $stable(sum_q))
	`BLA_ASSERT_IMPL(a_upper_levels_shown, clk, arst_n, out_valid_q && (level_q == LEVEL_FULL || level_q == LEVEL_TWO_BAR), show_q)

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Battery level averager testbench
// Drives sample beats and threshold writes into the averager and predicts
// every result with its own running-sum model of the sample window. Each
// result beat is checked field by field against the oldest prediction. The
// stimulus is a directed opening, then random phases with new thresholds and
// samples clustered near them, under several patterns of sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import batt_avg_pkg::*;

	localparam int WINDOW          = 128;
	localparam int BLINK_PERIOD_MS = 2000;
	localparam int BLINK_ON_MS     = 1000;
	localparam int CODE_MAX        = (1 << SAMPLE_W) - 1;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_SAMPLES   = 96;
	localparam int REPORT_LIMIT    = 10;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [TIME_W-1:0]   time_ms;
	} battery_reading_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		level_t              level;
		logic                show_graphic;
		logic                battery_low;
	} level_report_t;

	logic clk = 1'b0;
	logic arst_n;

	batt_avg_item_if   sample_ch();
	batt_avg_cfg_if    cfg_ch();
	batt_avg_result_if result_ch();

	battery_level_averager_top #(
		.WINDOW(WINDOW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.cfg(cfg_ch),
		.result_ch(result_ch)
	);

	battery_reading_t pending_readings[$];
	level_report_t    expected_reports[$];
	battery_reading_t next_reading;

	logic [SAMPLE_W-1:0] window_ring [WINDOW] = '{default: '0};
	int unsigned         ring_pos    = 0;
	int unsigned         window_sum  = 0;
	logic [SAMPLE_W-1:0] thr_full    = FULL_THR_RESET;
	logic [SAMPLE_W-1:0] thr_two_bar = TWO_BAR_THR_RESET;
	logic [SAMPLE_W-1:0] thr_low     = LOW_THR_RESET;

	int  send_idle_pct = 0;
	int  stall_pct     = 0;
	logic sample_taken = 1'b0;
	int  quiet_cycles  = 0;
	int  failures      = 0;
	int  samples_in    = 0;
	int  reports_out   = 0;
	int  reg_writes    = 0;
	int  level_hits [4] = '{default: 0};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic level_report_t predict_report(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
		level_report_t r;
		int unsigned   full_sum;
		int unsigned   two_sum;
		int unsigned   low_sum;
		full_sum = int'(thr_full) * WINDOW;
		two_sum = int'(thr_two_bar) * WINDOW;
		low_sum = int'(thr_low) * WINDOW;
		window_sum = window_sum - window_ring[ring_pos] + s;
		window_ring[ring_pos] = s;
		ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
		r.average = SAMPLE_W'(window_sum / WINDOW);
		if (window_sum >= full_sum) begin
			r.level = LEVEL_FULL;
		end else if (window_sum >= two_sum) begin
			r.level = LEVEL_TWO_BAR;
		end else if (window_sum >= low_sum) begin
			r.level = LEVEL_ONE_BAR;
		end else begin
			r.level = LEVEL_EMPTY;
		end
		if (r.level == LEVEL_FULL || r.level == LEVEL_TWO_BAR) begin
			r.show_graphic = 1'b1;
		end else begin
			r.show_graphic = (t % BLINK_PERIOD_MS) < BLINK_ON_MS;
		end
		r.battery_low = window_sum < low_sum;
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp_code(int v);
		return (v < 0) ? '0 : (v > CODE_MAX) ? SAMPLE_W'(CODE_MAX) : SAMPLE_W'(v);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_threshold();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0) begin
			return '0;
		end else if (roll == 1) begin
			return SAMPLE_W'(CODE_MAX);
		end
		return SAMPLE_W'($urandom_range(0, CODE_MAX));
	endfunction

	always @(posedge clk) begin
		sample_taken <= sample_ch.valid && sample_ch.ready;
		if (sample_ch.valid && sample_ch.ready) begin
			expected_reports.push_back(predict_report(sample_ch.sample, sample_ch.time_ms));
			samples_in++;
		end
	end

	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				CFG_FULL_THR: thr_full <= cfg_ch.data;
				CFG_TWO_BAR_THR: thr_two_bar <= cfg_ch.data;
				CFG_LOW_THR: thr_low <= cfg_ch.data;
				default: ;
			endcase
			reg_writes++;
		end
	end

	always @(negedge clk) begin
		if (!sample_ch.valid || sample_taken) begin
			if (pending_readings.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_reading = pending_readings.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.sample <= next_reading.sample;
				sample_ch.time_ms <= next_reading.time_ms;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= $urandom_range(0, 99) >= stall_pct;
	end

	always @(posedge clk) begin
		level_report_t want;
		if (result_ch.valid && result_ch.ready) begin
			reports_out++;
			if (expected_reports.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("unexpected result beat: avg %0d level %0d show %0b low %0b",
						result_ch.average, result_ch.level, result_ch.show_graphic,
						result_ch.battery_low);
				end
			end else begin
				want = expected_reports.pop_front();
				level_hits[want.level]++;
				if (result_ch.average !== want.average || result_ch.level !== want.level ||
					result_ch.show_graphic !== want.show_graphic ||
					result_ch.battery_low !== want.battery_low) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("result %0d mismatch: expected avg %0d level %0d show %0b low %0b,",
							reports_out, want.average, want.level, want.show_graphic,
							want.battery_low,
							" got avg %0d level %0d show %0b low %0b",
							result_ch.average, result_ch.level,
							result_ch.show_graphic, result_ch.battery_low);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("watchdog expired after %0d cycles without a beat", WATCHDOG_LIMIT);
		$display("battery_level_averager_top verification failed");
		$finish;
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 61;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 61;
			end
			default: begin
				send_idle_pct = 26;
				stall_pct = 26;
			end
		endcase
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_thresholds(logic [SAMPLE_W-1:0] full, logic [SAMPLE_W-1:0] two_bar,
		logic [SAMPLE_W-1:0] low);
		write_register(CFG_FULL_THR, full);
		write_register(CFG_TWO_BAR_THR, two_bar);
		write_register(CFG_LOW_THR, low);
	endtask

	task automatic queue_reading(int s, logic [TIME_W-1:0] t);
		battery_reading_t r;
		r.sample = clamp_code(s);
		r.time_ms = t;
		pending_readings.push_back(r);
	endtask

	task automatic drain_and_wait();
		while (pending_readings.size() != 0 || sample_ch.valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(idle_mode_t mode);
		logic [SAMPLE_W-1:0] thr [3];
		logic [SAMPLE_W-1:0] swap;
		logic [TIME_W-1:0]   t;
		int                  center;
		for (int i = 0; i < 3; i++) thr[i] = pick_threshold();
		if ($urandom_range(0, 3) != 0) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2 - i; j++) begin
					if (thr[j] < thr[j + 1]) begin
						swap = thr[j];
						thr[j] = thr[j + 1];
						thr[j + 1] = swap;
					end
				end
			end
		end
		set_thresholds(thr[0], thr[1], thr[2]);
		if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED_INDEX, pick_threshold());
		set_idling(mode);
		center = 0;
		for (int n = 0; n < PHASE_SAMPLES; n++) begin
			if (n % 32 == 0) center = int'(thr[$urandom_range(0, 2)]) + $urandom_range(0, 160) - 80;
			if ($urandom_range(0, 3) == 0) begin
				t = TIME_W'($urandom_range(1, 4294966)) * BLINK_ON_MS - $urandom_range(0, 1);
			end else begin
				t = $urandom;
			end
			if ($urandom_range(0, 9) == 0) begin
				queue_reading($urandom_range(0, CODE_MAX), t);
			end else begin
				queue_reading(center + $urandom_range(0, 64) - 32, t);
			end
		end
		drain_and_wait();
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.time_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idling(IDLE_NONE);
		queue_reading(0, 0);
		queue_reading(CODE_MAX, 999);
		queue_reading(CODE_MAX, 1000);
		queue_reading(0, 32'hFFFF_FFFF);
		drain_and_wait();

		set_thresholds(12'd96, 12'd48, 12'd16);
		set_idling(IDLE_BOTH);
		queue_reading(CODE_MAX, 0);
		queue_reading(CODE_MAX, 999);
		queue_reading(CODE_MAX, 1000);
		queue_reading(CODE_MAX, 1999);
		queue_reading(CODE_MAX, 2000);
		queue_reading(CODE_MAX, 32'hFFFF_FFFF);
		queue_reading(CODE_MAX, 2999);
		queue_reading(CODE_MAX, 3000);
		drain_and_wait();

		set_idling(IDLE_NONE);
		set_thresholds(SAMPLE_W'(CODE_MAX), 12'd0, SAMPLE_W'(CODE_MAX));
		queue_reading(CODE_MAX, 1500);
		queue_reading(0, 500);
		queue_reading(2048, 32'h8000_0000);
		drain_and_wait();
		set_thresholds(12'd0, SAMPLE_W'(CODE_MAX), 12'd0);
		write_register(CFG_UNUSED_INDEX, SAMPLE_W'(CODE_MAX));
		queue_reading(0, 1500);
		queue_reading(CODE_MAX, 32'h7FFF_FFFF);
		queue_reading(1365, 32'h5555_5555);
		drain_and_wait();

		for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(idle_mode_t'(p % 4));

		$display("Checked %0d results from %0d sample beats across %0d register writes.",
			reports_out, samples_in, reg_writes);
		$display("Levels seen: full %0d, two bars %0d, one bar %0d, empty %0d; failures %0d.",
			level_hits[LEVEL_FULL], level_hits[LEVEL_TWO_BAR], level_hits[LEVEL_ONE_BAR],
			level_hits[LEVEL_EMPTY], failures);
		if (failures == 0 && expected_reports.size() == 0) begin
			$display("battery_level_averager_top verification clean");
		end else begin
			$display("battery_level_averager_top verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/batt_avg_pkg.sv
rtl/core/batt_avg_if.sv
rtl/core/battery_level_averager_top.sv
sim/testbench.sv
